// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tlbsa_pkg.sv =====
// Package of the two-level bitmap slot allocator: command and status codes,
// field widths and the command/status structs between controller and datapath.
// Depends on nothing.
package tlbsa_pkg;

    // Field widths of the request and response words.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 6;
    localparam int OCC_W    = 7;
    localparam int CFG_W    = 7;

    // Request commands; the unused code behaves as a check.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd2;

    // Reset value of the slots-per-page register.
    localparam logic [CFG_W-1:0] SPP_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_we;   // write one zero row of the clearing pass
        logic capture;  // latch the request and start the map read
        logic exec;     // modify the row, write it back, load the response
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // the clearing pass is at its last row
    } t_dp_stat;

endpackage

// ===== rtl/core/tlbsa_req_if.sv =====
// Request channel of the slot allocator: valid/ready and the request word.
// Depends on tlbsa_pkg.
interface tlbsa_req_if;
    logic                          valid;
    logic                          ready;
    logic [tlbsa_pkg::CMD_W-1:0]   command;
    logic [tlbsa_pkg::IDX_W-1:0]   page_index;
    logic [tlbsa_pkg::IDX_W-1:0]   slot_index;

    modport source (output valid, command, page_index, slot_index, input ready);
    modport sink   (input valid, command, page_index, slot_index, output ready);
endinterface

// ===== rtl/core/tlbsa_rsp_if.sv =====
// Response channel of the slot allocator: valid/ready and the response word.
// Depends on tlbsa_pkg.
interface tlbsa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [tlbsa_pkg::STATUS_W-1:0]   status;
    logic [tlbsa_pkg::IDX_W-1:0]      result_page;
    logic [tlbsa_pkg::IDX_W-1:0]      result_slot;
    logic [tlbsa_pkg::OCC_W-1:0]      page_occupancy;

    modport source (output valid, status, result_page, result_slot, page_occupancy,
                    input ready);
    modport sink   (input valid, status, result_page, result_slot, page_occupancy,
                    output ready);
endinterface

// ===== rtl/core/two_level_bitmap_slot_allocator_unit.sv =====
// Top level of the two-level bitmap slot allocator.
// Depends on tlbsa_pkg, tlbsa_req_if, tlbsa_rsp_if, tlbsa_ram, tlbsa_ctrl, tlbsa_dp.
//
// Usage:
//   i_req carries one request word (allocate, release or check of a slot);
//   o_rsp returns exactly one response word per request, in order. Both are
//   valid/ready channels. i_cfg_we/i_cfg_wdata write the slots-per-page limit;
//   write it only while no request is in flight.
// Request sequence:
//   The page row is read at the edge that takes the request; the execute step
//   that follows modifies it, writes it back and loads the response word,
//   which is then valid. No new request is taken during the execute step, as
//   the row memory that holds maps and counts is in its read-modify-write.
// Reset:
//   Reset clears the full-page map and the limit goes to 64. The row memory
//   is then zeroed by a clearing pass over all NUM_PAGES rows, during which
//   i_req.ready is low.
// Stall:
//   While a response waits on o_rsp, the next request is taken only in the
//   cycle in which that response is taken; the response word holds meanwhile.
module two_level_bitmap_slot_allocator_unit #(
    parameter int NUM_PAGES = 64,
    parameter int SLOT_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tlbsa_req_if.sink                    i_req,
    tlbsa_rsp_if.source                  o_rsp,
    input  logic                         i_cfg_we,
    input  logic [tlbsa_pkg::CFG_W-1:0]  i_cfg_wdata
);

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int ROW_W  = SLOT_BITS + $clog2(SLOT_BITS + 1);

    tlbsa_pkg::t_dp_cmd  dp_cmd;
    tlbsa_pkg::t_dp_stat dp_stat;

    logic              ram_we;
    logic [PAGE_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [PAGE_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    // Sequencer for the clearing pass, handshakes and execute step.
    tlbsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // Search, update and response datapath.
    tlbsa_dp #(
        .NUM_PAGES (NUM_PAGES),
        .SLOT_BITS (SLOT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_command        (i_req.command),
        .i_page_index     (i_req.page_index),
        .i_slot_index     (i_req.slot_index),
        .o_status         (o_rsp.status),
        .o_result_page    (o_rsp.result_page),
        .o_result_slot    (o_rsp.result_slot),
        .o_page_occupancy (o_rsp.page_occupancy),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata)
    );

    // One row per page: slot map in the low bits, occupancy count on top.
    tlbsa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_PAGES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== rtl/core/tlbsa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module tlbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/tlbsa_ctrl.sv =====
// Controller of the slot allocator: clearing pass, request handshake,
// execute step and the response valid flag. Depends on tlbsa_pkg, assert_macros.svh.
`include "assert_macros.svh"

module tlbsa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tlbsa_pkg::t_dp_cmd   o_cmd,
    input  tlbsa_pkg::t_dp_stat  i_stat
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;
    tlbsa_pkg::t_dp_cmd cmd;

    // Next state and datapath commands. A request is taken only when the
    // response register is empty or being emptied in the same cycle.
    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = !r_out_valid || i_out_ready;
                if (in_ready && i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Response valid: set by the execute step, cleared when the word is taken.
    always_comb begin
        if (cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Every execute step leaves a response waiting.
    `ASSERT_NEXT(a_exec_gives_rsp, i_clk, i_rst_n, r_state == S_EXEC, r_out_valid, "execute step without response")
    // A response only appears right after an execute step.
    `ASSERT_IMPLIES(a_rsp_from_exec, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_EXEC, "response without execute step")

endmodule

// ===== rtl/core/tlbsa_dp.sv =====
// Datapath of the slot allocator: full-page map, find-first-zero on pages and
// slots, row read-modify-write and response register. Depends on tlbsa_pkg,
// assert_macros.svh; drives the ports of one tlbsa_ram.
`include "assert_macros.svh"

module tlbsa_dp #(
    parameter int NUM_PAGES = 64,
    parameter int SLOT_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tlbsa_pkg::t_dp_cmd                   i_cmd,
    output tlbsa_pkg::t_dp_stat                  o_stat,
    // configuration register write
    input  logic                                 i_cfg_we,
    input  logic [tlbsa_pkg::CFG_W-1:0]          i_cfg_wdata,
    // request word
    input  logic [tlbsa_pkg::CMD_W-1:0]          i_command,
    input  logic [tlbsa_pkg::IDX_W-1:0]          i_page_index,
    input  logic [tlbsa_pkg::IDX_W-1:0]          i_slot_index,
    // response word
    output logic [tlbsa_pkg::STATUS_W-1:0]       o_status,
    output logic [tlbsa_pkg::IDX_W-1:0]          o_result_page,
    output logic [tlbsa_pkg::IDX_W-1:0]          o_result_slot,
    output logic [tlbsa_pkg::OCC_W-1:0]          o_page_occupancy,
    // row memory: slot map and count of each page
    output logic                                 o_ram_we,
    output logic [$clog2(NUM_PAGES)-1:0]         o_ram_waddr,
    output logic [SLOT_BITS+$clog2(SLOT_BITS+1)-1:0] o_ram_wdata,
    output logic                                 o_ram_re,
    output logic [$clog2(NUM_PAGES)-1:0]         o_ram_raddr,
    input  logic [SLOT_BITS+$clog2(SLOT_BITS+1)-1:0] i_ram_rdata
);

    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int SLOT_W = $clog2(SLOT_BITS);
    localparam int CNT_W  = $clog2(SLOT_BITS + 1);
    localparam int CMP_W  = (CNT_W > tlbsa_pkg::CFG_W) ? CNT_W : tlbsa_pkg::CFG_W;
    localparam int IDX_W  = tlbsa_pkg::IDX_W;
    localparam int OCC_W  = tlbsa_pkg::OCC_W;

    // Configuration and map state.
    logic [tlbsa_pkg::CFG_W-1:0] r_spp;
    logic [NUM_PAGES-1:0]        r_full;
    logic [PAGE_W-1:0]           r_clr_addr;

    // Captured request.
    logic [tlbsa_pkg::CMD_W-1:0] r_cmd;
    logic [IDX_W-1:0]            r_page;
    logic [IDX_W-1:0]            r_slot;
    logic [PAGE_W-1:0]           r_addr;
    logic                        r_oor;
    logic                        r_nofree;

    // Response register.
    logic [tlbsa_pkg::STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]               r_res_page;
    logic [IDX_W-1:0]               r_res_slot;
    logic [OCC_W-1:0]               r_res_occ;

    logic [NUM_PAGES-1:0] page_free_oh;
    logic [PAGE_W-1:0]    page_first;
    logic                 in_oor;

    logic [SLOT_BITS-1:0] w;
    logic [CNT_W-1:0]     cnt;
    logic [SLOT_BITS-1:0] slot_free_oh;
    logic [SLOT_W-1:0]    slot_first;
    logic                 has_free;
    logic [SLOT_W-1:0]    slot_sel;
    logic [SLOT_BITS-1:0] bit_oh;
    logic                 cur_bit;
    logic                 is_alloc;
    logic                 is_rel;
    logic                 alloc_ok;
    logic                 rel_ok;
    logic [CNT_W-1:0]     new_cnt;
    logic [SLOT_BITS-1:0] new_w;
    logic [CMP_W-1:0]     spp_x;
    logic [CMP_W-1:0]     max_x;
    logic [CMP_W-1:0]     lim;
    logic                 reaches;

    logic [tlbsa_pkg::STATUS_W-1:0] n_status;
    logic [IDX_W-1:0]               n_res_page;
    logic [IDX_W-1:0]               n_res_slot;
    logic [CNT_W-1:0]               n_res_cnt;
    logic [PAGE_W+IDX_W-1:0]        page_ext;
    logic [SLOT_W+IDX_W-1:0]        slot_ext;
    logic [CNT_W+OCC_W-1:0]         occ_ext;

    // Lowest page whose full bit is clear: isolate the lowest zero, then encode.
    always_comb begin
        page_free_oh = ~r_full & (r_full + NUM_PAGES'(1));
        page_first   = '0;
        for (int i = 0; i < NUM_PAGES; i++) begin
            if (page_free_oh[i]) begin
                page_first = page_first | PAGE_W'(i);
            end
        end
    end

    // Release and check addresses beyond the configured store are refused.
    assign in_oor = (32'(i_page_index) >= 32'(NUM_PAGES))
                 || (32'(i_slot_index) >= 32'(SLOT_BITS));

    // Row read at capture: the chosen page for allocate, else the given page.
    assign o_ram_re    = i_cmd.capture;
    assign o_ram_raddr = (i_command == tlbsa_pkg::CMD_ALLOC) ? page_first
                                                              : PAGE_W'(i_page_index);

    // Split the row read back from memory.
    assign w   = i_ram_rdata[SLOT_BITS-1:0];
    assign cnt = i_ram_rdata[SLOT_BITS+CNT_W-1:SLOT_BITS];

    // Lowest clear slot of the row.
    always_comb begin
        slot_free_oh = ~w & (w + SLOT_BITS'(1));
        slot_first   = '0;
        for (int i = 0; i < SLOT_BITS; i++) begin
            if (slot_free_oh[i]) begin
                slot_first = slot_first | SLOT_W'(i);
            end
        end
    end

    assign has_free = ~&w;
    assign is_alloc = (r_cmd == tlbsa_pkg::CMD_ALLOC);
    assign is_rel   = (r_cmd == tlbsa_pkg::CMD_RELEASE);
    assign slot_sel = is_alloc ? slot_first : SLOT_W'(r_slot);
    assign bit_oh   = is_alloc ? slot_free_oh : (SLOT_BITS'(1) << slot_sel);
    assign cur_bit  = |(w & bit_oh);
    assign alloc_ok = is_alloc && !r_nofree && has_free;
    assign rel_ok   = is_rel && !r_oor && cur_bit;

    // Count update saturates at zero and at the row width.
    always_comb begin
        if (is_alloc) begin
            new_cnt = (cnt < CNT_W'(SLOT_BITS)) ? cnt + CNT_W'(1) : cnt;
            new_w   = w | bit_oh;
        end else begin
            new_cnt = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
            new_w   = w & ~bit_oh;
        end
    end

    // Effective page limit: the register clamped to one through the row width.
    always_comb begin
        spp_x = CMP_W'(r_spp);
        max_x = CMP_W'(SLOT_BITS);
        if (spp_x == '0) begin
            lim = CMP_W'(1);
        end else if (spp_x > max_x) begin
            lim = max_x;
        end else begin
            lim = spp_x;
        end
    end

    assign reaches = CMP_W'(new_cnt) >= lim;

    // Row write: zero rows during the clearing pass, else the modified row.
    assign o_ram_we    = i_cmd.clr_we || (i_cmd.exec && (alloc_ok || rel_ok));
    assign o_ram_waddr = i_cmd.clr_we ? r_clr_addr : r_addr;
    assign o_ram_wdata = i_cmd.clr_we ? '0 : {new_cnt, new_w};

    assign o_stat.clr_last = (r_clr_addr == PAGE_W'(NUM_PAGES - 1));

    // Response word of the current request.
    always_comb begin
        n_res_page = r_page;
        n_res_slot = r_slot;
        n_res_cnt  = '0;
        page_ext   = (PAGE_W + IDX_W)'(r_addr);
        slot_ext   = (SLOT_W + IDX_W)'(slot_first);
        if (is_alloc) begin
            if (alloc_ok) begin
                n_status   = tlbsa_pkg::ST_OK;
                n_res_page = page_ext[IDX_W-1:0];
                n_res_slot = slot_ext[IDX_W-1:0];
                n_res_cnt  = new_cnt;
            end else begin
                n_status   = tlbsa_pkg::ST_NO_FREE;
                n_res_page = '0;
                n_res_slot = '0;
            end
        end else if (r_oor) begin
            n_status = tlbsa_pkg::ST_NO_ENTRY;
        end else if (!cur_bit) begin
            n_status  = tlbsa_pkg::ST_NO_ENTRY;
            n_res_cnt = cnt;
        end else begin
            n_status  = tlbsa_pkg::ST_OK;
            n_res_cnt = is_rel ? new_cnt : cnt;
        end
        occ_ext = (CNT_W + OCC_W)'(n_res_cnt);
    end

    // Control state: configuration, full map and clearing counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp      <= tlbsa_pkg::SPP_RESET;
            r_full     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_spp <= i_cfg_wdata;
            end
            if (i_cmd.clr_we) begin
                r_clr_addr <= r_clr_addr + PAGE_W'(1);
            end
            if (i_cmd.exec && alloc_ok && reaches) begin
                r_full[r_addr] <= 1'b1;
            end else if (i_cmd.exec && rel_ok && !reaches) begin
                r_full[r_addr] <= 1'b0;
            end
        end
    end

    // Request capture and response register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_command;
            r_page   <= i_page_index;
            r_slot   <= i_slot_index;
            r_addr   <= o_ram_raddr;
            r_oor    <= in_oor;
            r_nofree <= &r_full;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_res_page <= n_res_page;
            r_res_slot <= n_res_slot;
            r_res_occ  <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_status         = r_status;
    assign o_result_page    = r_res_page;
    assign o_result_slot    = r_res_slot;
    assign o_page_occupancy = r_res_occ;

    // A page marked full is never chosen for an allocation.
    `ASSERT_IMPLIES(a_alloc_not_full, i_clk, i_rst_n, i_cmd.exec && alloc_ok, !r_full[r_addr], "allocation on a full page")
    // A row written back never counts more slots than it has.
    `ASSERT_IMPLIES(a_cnt_bound, i_clk, i_rst_n, o_ram_we, o_ram_wdata[SLOT_BITS+CNT_W-1:SLOT_BITS] <= CNT_W'(SLOT_BITS), "slot count beyond row width")

endmodule
